FILE: rtl/dcrc_pkg.sv
package dcrc_pkg;

    // Word widths on the stream ports
    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 216;
    localparam int M_TUSER_W = 8;

    // Default depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 2;

    // Header codes
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] SERVER_PORT_RST = 16'd53;

    // Frame length minima
    localparam logic [15:0] MIN_LEN_V4     = 16'd54;
    localparam logic [15:0] MIN_LEN_V6     = 16'd74;
    localparam logic [15:0] MIN_TCP_DNS_V4 = 16'd68;
    localparam logic [15:0] MIN_TCP_DNS_V6 = 16'd88;
    localparam logic [15:0] IPV4_HDR_BYTES = 16'd20;

    // TCP flag masks
    localparam logic [7:0] FLAGS_SYN_ACK  = 8'h12;
    localparam logic [7:0] FLAGS_SYN_FIN  = 8'h03;
    localparam logic [7:0] FLAGS_ACK      = 8'h10;
    localparam logic [7:0] FLAGS_FIN_ACK  = 8'h11;

    typedef enum logic [2:0] {
        ACT_DROP      = 3'd0,
        ACT_ACK       = 3'd1,
        ACT_ACK_QUERY = 3'd2,
        ACT_FIN_ACK   = 3'd3,
        ACT_UDP       = 3'd4
    } action_t;

    // Classified word passed from the front part to the back part
    typedef struct packed {
        action_t     action;
        logic        count_rsp;
        logic [3:0]  rcode;
        logic [15:0] frame_len;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] ack_add;
        logic [15:0] rx_sport;
        logic [15:0] rx_dport;
    } cls_word_t;

endpackage

FILE: rtl/dcrc_front.sv
module dcrc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [15:0]                 cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dcrc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                        cls_valid,
    input  logic                        cls_ready,
    output dcrc_pkg::cls_word_t         cls_word
);
    import dcrc_pkg::*;

    logic [15:0] server_port_reg;
    logic        valid_reg;
    cls_word_t   word_reg;
    cls_word_t   word_next;

    // Unpack the input word
    logic [15:0] frame_len;
    logic [15:0] eth_kind;
    logic [7:0]  ip_proto;
    logic [15:0] ip_length;
    logic [7:0]  tcp_offset_byte;
    logic [15:0] l4_src_port;
    logic [15:0] l4_dst_port;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [3:0]  dns_rcode;

    assign frame_len       = s_tdata[15:0];
    assign eth_kind        = s_tdata[31:16];
    assign ip_proto        = s_tdata[39:32];
    assign ip_length       = s_tdata[55:40];
    assign tcp_offset_byte = s_tdata[63:56];
    assign l4_src_port     = s_tdata[79:64];
    assign l4_dst_port     = s_tdata[95:80];
    assign tcp_flag_bits   = s_tdata[103:96];
    assign seq_number      = s_tdata[135:104];
    assign ack_number      = s_tdata[167:136];
    assign dns_rcode       = s_tdata[171:168];

    logic        is_v4;
    logic        l3_ok;
    logic        is_tcp;
    logic        is_udp;
    logic        port_ok;
    logic [15:0] tcp_dns_min;
    logic [15:0] pay_len;
    action_t     action;

    // Classify the frame and pick the action
    always_comb begin
        is_v4       = (eth_kind == ETH_IPV4);
        l3_ok       = (frame_len >= MIN_LEN_V4) &&
                      (is_v4 || ((eth_kind == ETH_IPV6) && (frame_len >= MIN_LEN_V6)));
        is_tcp      = l3_ok && (ip_proto == PROTO_TCP);
        is_udp      = l3_ok && (ip_proto == PROTO_UDP);
        port_ok     = (l4_src_port == server_port_reg);
        tcp_dns_min = is_v4 ? MIN_TCP_DNS_V4 : MIN_TCP_DNS_V6;
        action      = ACT_DROP;
        if (is_tcp && port_ok) begin
            if ((tcp_flag_bits & FLAGS_SYN_ACK) == FLAGS_SYN_ACK) begin
                action = ACT_ACK_QUERY;
            end else if ((tcp_flag_bits & FLAGS_SYN_FIN) != 8'h00) begin
                action = ACT_ACK;
            end else if (frame_len >= tcp_dns_min) begin
                action = ACT_FIN_ACK;
            end
        end else if (is_udp && port_ok) begin
            action = ACT_UDP;
        end

        // Payload length; non-positive values acknowledge one byte
        pay_len = ip_length - (is_v4 ? IPV4_HDR_BYTES : 16'd0)
                  - {10'd0, tcp_offset_byte[7:2]};

        word_next           = '0;
        word_next.action    = action;
        word_next.count_rsp = (action == ACT_FIN_ACK) || (action == ACT_UDP);
        word_next.rcode     = dns_rcode;
        word_next.frame_len = frame_len;
        if (action inside {ACT_ACK, ACT_ACK_QUERY, ACT_FIN_ACK}) begin
            word_next.seq_number = seq_number;
            word_next.ack_number = ack_number;
            word_next.ack_add    = ((pay_len != 16'd0) && !pay_len[15]) ?
                                   pay_len : 16'd1;
            word_next.rx_sport   = l4_src_port;
            word_next.rx_dport   = l4_dst_port;
        end
    end

    assign s_tready  = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls_word  = word_reg;

    // Hold the server port and advance the classified word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_port_reg <= SERVER_PORT_RST;
            valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                server_port_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                valid_reg <= s_tvalid;
            end
        end
        if (s_tready && s_tvalid) begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: rtl/dcrc_queue.sv
module dcrc_queue #(
    parameter int DEPTH = dcrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  dcrc_pkg::cls_word_t push_word,
    output logic                pop_valid,
    input  logic                pop_ready,
    output dcrc_pkg::cls_word_t pop_word
);
    import dcrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_word_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/dcrc_back.sv
module dcrc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cls_valid,
    output logic                        cls_ready,
    input  dcrc_pkg::cls_word_t         cls_word,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dcrc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [dcrc_pkg::M_TUSER_W-1:0] m_tuser
);
    import dcrc_pkg::*;

    logic [47:0] bytes_reg;
    logic [31:0] resp_reg;
    logic [31:0] rcode_cnt_reg [16];

    logic        m_valid_reg;
    action_t     action_reg;
    logic [31:0] reply_seq_reg;
    logic [31:0] reply_ack_reg;
    logic [7:0]  reply_flags_reg;
    logic [15:0] reply_src_reg;
    logic [15:0] reply_dst_reg;
    logic [47:0] bytes_out_reg;
    logic [31:0] resp_out_reg;
    logic [31:0] rcode_out_reg;

    logic        do_pop;
    logic [47:0] bytes_next;
    logic [31:0] resp_next;
    logic [31:0] rcode_cur;
    logic [31:0] rcode_next;
    logic        has_reply;

    assign cls_ready = !m_valid_reg || m_tready;
    assign do_pop    = cls_valid && cls_ready;

    // Update counters for the popped word
    always_comb begin
        bytes_next = bytes_reg + {32'd0, cls_word.frame_len};
        rcode_cur  = rcode_cnt_reg[cls_word.rcode];
        resp_next  = cls_word.count_rsp ? resp_reg + 32'd1 : resp_reg;
        rcode_next = cls_word.count_rsp ? rcode_cur + 32'd1 : rcode_cur;
        has_reply  = (cls_word.action inside {ACT_ACK, ACT_ACK_QUERY, ACT_FIN_ACK});
    end

    // Hold counters and the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg   <= '0;
            resp_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                rcode_cnt_reg[i] <= '0;
            end
        end else begin
            if (cls_ready) begin
                m_valid_reg <= cls_valid;
            end
            if (do_pop) begin
                bytes_reg                     <= bytes_next;
                resp_reg                      <= resp_next;
                rcode_cnt_reg[cls_word.rcode] <= rcode_next;
            end
        end
        if (do_pop) begin
            action_reg      <= cls_word.action;
            reply_seq_reg   <= cls_word.ack_number;
            reply_ack_reg   <= has_reply ?
                               cls_word.seq_number + {16'd0, cls_word.ack_add} : 32'd0;
            reply_flags_reg <= !has_reply ? 8'h00 :
                               (cls_word.action == ACT_FIN_ACK) ? FLAGS_FIN_ACK : FLAGS_ACK;
            reply_src_reg   <= cls_word.rx_dport;
            reply_dst_reg   <= cls_word.rx_sport;
            bytes_out_reg   <= bytes_next;
            resp_out_reg    <= resp_next;
            rcode_out_reg   <= rcode_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {5'd0, action_reg};
    assign m_tdata  = {rcode_out_reg, resp_out_reg, bytes_out_reg, reply_dst_reg,
                       reply_src_reg, reply_flags_reg, reply_ack_reg, reply_seq_reg};

endmodule

FILE: rtl/dns_client_reply_classifier_unit.sv
// Classifies one parsed frame header per word and reports the client's reaction
// (drop, ack, ack then query, fin-ack response, udp response) with the reply TCP
// numbers and the running byte, response and per-rcode counters. A word can be
// accepted every clock while the output is not stalled; its result word passes
// through the front register, a queue entry and the back register before it is
// presented. The back part's counter update (one 48-bit byte add and one
// rcode counter read-modify-write) sets that one-word-per-clock figure.
// A queue of QUEUE_DEPTH words sits between the classifying front part and the
// counting back part. server_port resets to 53 and is written through cfg_wr_en.
module dns_client_reply_classifier_unit #(
    parameter int QUEUE_DEPTH = dcrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data,   // server_port
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_len, eth_kind, ip_proto, ip_length, tcp_offset_byte, l4_src_port,
    // l4_dst_port, tcp_flag_bits, seq_number, ack_number, dns_rcode, zero pad
    input  logic [dcrc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // reply_seq, reply_ack, reply_flags, reply_src_port, reply_dst_port,
    // bytes_total, responses_total, rcode_total
    output logic [dcrc_pkg::M_TDATA_W-1:0]  m_tdata,
    // action, zero pad
    output logic [dcrc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import dcrc_pkg::*;

    logic      fr_valid;
    logic      fr_ready;
    cls_word_t fr_word;
    logic      bk_valid;
    logic      bk_ready;
    cls_word_t bk_word;

    dcrc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cls_valid   (fr_valid),
        .cls_ready   (fr_ready),
        .cls_word    (fr_word)
    );

    dcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_word  (fr_word),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_word   (bk_word)
    );

    dcrc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_valid (bk_valid),
        .cls_ready (bk_ready),
        .cls_word  (bk_word),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import dcrc_pkg::*;

    // One received frame header summary
    typedef struct {
        logic [15:0] frame_len;
        logic [15:0] eth_kind;
        logic [7:0]  ip_proto;
        logic [15:0] ip_length;
        logic [7:0]  tcp_offset_byte;
        logic [15:0] l4_src_port;
        logic [15:0] l4_dst_port;
        logic [7:0]  tcp_flag_bits;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [3:0]  dns_rcode;
    } frame_t;

    // Reaction and counters reported for one frame
    typedef struct {
        action_t     action;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [7:0]  reply_flags;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [47:0] bytes_total;
        logic [31:0] responses_total;
        logic [31:0] rcode_total;
    } reply_t;

    localparam int RX_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES    = 8;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [15:0]          cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow of the block's counters and server port
    logic [47:0] byte_count;
    logic [31:0] rsp_count;
    logic [31:0] rcode_count [16];
    logic [15:0] srv_port;

    reply_t expected_replies [$];
    reply_t want;
    int     mismatch_count = 0;
    bit     idle_on        = 1'b1;
    bit     rx_hold_req    = 1'b0;

    dns_client_reply_classifier_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Work out the reaction to one frame and advance the shadow counters
    function automatic reply_t classify_frame(input frame_t f);
        reply_t      r;
        logic        is_v4;
        logic        is_tcp;
        logic        is_udp;
        logic        counted;
        logic [15:0] payload;
        logic [31:0] ack_add;
        is_v4   = (f.eth_kind == ETH_IPV4);
        is_tcp  = 1'b0;
        is_udp  = 1'b0;
        counted = 1'b0;
        r.action         = ACT_DROP;
        r.reply_seq      = '0;
        r.reply_ack      = '0;
        r.reply_flags    = '0;
        r.reply_src_port = '0;
        r.reply_dst_port = '0;
        byte_count = byte_count + {32'd0, f.frame_len};
        if (f.frame_len >= MIN_LEN_V4 &&
            (is_v4 || (f.eth_kind == ETH_IPV6 && f.frame_len >= MIN_LEN_V6))) begin
            is_tcp = (f.ip_proto == PROTO_TCP);
            is_udp = (f.ip_proto == PROTO_UDP);
        end
        if (is_tcp && f.l4_src_port == srv_port) begin
            if ((f.tcp_flag_bits & FLAGS_SYN_ACK) == FLAGS_SYN_ACK) begin
                r.action = ACT_ACK_QUERY;
            end else if ((f.tcp_flag_bits & FLAGS_SYN_FIN) != 8'd0) begin
                r.action = ACT_ACK;
            end else if (f.frame_len >= (is_v4 ? MIN_TCP_DNS_V4 : MIN_TCP_DNS_V6)) begin
                r.action = ACT_FIN_ACK;
                counted  = 1'b1;
            end
        end else if (is_udp && f.l4_src_port == srv_port) begin
            r.action = ACT_UDP;
            counted  = 1'b1;
        end
        if (counted) begin
            rsp_count = rsp_count + 32'd1;
            rcode_count[f.dns_rcode] = rcode_count[f.dns_rcode] + 32'd1;
        end
        // Reply TCP header for the three acknowledging reactions
        if (r.action == ACT_ACK || r.action == ACT_ACK_QUERY || r.action == ACT_FIN_ACK) begin
            payload = f.ip_length - (is_v4 ? IPV4_HDR_BYTES : 16'd0)
                    - {10'd0, f.tcp_offset_byte[7:2]};
            ack_add = (payload != 16'd0 && !payload[15]) ? {16'd0, payload} : 32'd1;
            r.reply_seq      = f.ack_number;
            r.reply_ack      = f.seq_number + ack_add;
            r.reply_flags    = (r.action == ACT_FIN_ACK) ? FLAGS_FIN_ACK : FLAGS_ACK;
            r.reply_src_port = f.l4_dst_port;
            r.reply_dst_port = f.l4_src_port;
        end
        r.bytes_total     = byte_count;
        r.responses_total = rsp_count;
        r.rcode_total     = rcode_count[f.dns_rcode];
        return r;
    endfunction

    // Well-formed frame with consistent lengths and random numbers
    function automatic frame_t good_frame(input bit v6, input logic [7:0] proto,
                                          input logic [7:0] flags, input logic [15:0] flen);
        frame_t f;
        f.frame_len       = flen;
        f.eth_kind        = v6 ? ETH_IPV6 : ETH_IPV4;
        f.ip_proto        = proto;
        f.ip_length       = v6 ? flen - 16'd54 : flen - 16'd14;
        f.tcp_offset_byte = 8'h50;
        f.l4_src_port     = srv_port;
        f.l4_dst_port     = 16'($urandom);
        f.tcp_flag_bits   = flags;
        f.seq_number      = $urandom;
        f.ack_number      = $urandom;
        f.dns_rcode       = 4'($urandom);
        return f;
    endfunction

    // Mostly well-formed frames, some at the length limits, the rest pure noise
    function automatic frame_t random_frame();
        frame_t f;
        int     pick;
        bit     v6;
        f.frame_len       = 16'($urandom);
        f.eth_kind        = 16'($urandom);
        f.ip_proto        = 8'($urandom);
        f.ip_length       = 16'($urandom);
        f.tcp_offset_byte = 8'($urandom);
        f.l4_src_port     = 16'($urandom);
        f.l4_dst_port     = 16'($urandom);
        f.tcp_flag_bits   = 8'($urandom);
        f.seq_number      = $urandom;
        f.ack_number      = $urandom;
        f.dns_rcode       = 4'($urandom);
        if ($urandom_range(0, 3) == 0)
            return f;
        v6 = ($urandom_range(0, 2) == 0);
        f.eth_kind = v6 ? ETH_IPV6 : ETH_IPV4;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            f.ip_proto = PROTO_TCP;
        else if (pick < 9)
            f.ip_proto = PROTO_UDP;
        // Frame length: at a limit, typical, or very long
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            case ($urandom_range(0, 7))
                0: f.frame_len = 16'd53;
                1: f.frame_len = 16'd54;
                2: f.frame_len = 16'd67;
                3: f.frame_len = 16'd68;
                4: f.frame_len = 16'd73;
                5: f.frame_len = 16'd74;
                6: f.frame_len = 16'd87;
                default: f.frame_len = 16'd88;
            endcase
        end else if (pick < 9) begin
            f.frame_len = 16'($urandom_range(54, 1514));
        end else begin
            f.frame_len = 16'($urandom_range(1515, 65535));
        end
        if ($urandom_range(0, 5) != 0)
            f.ip_length = v6 ? f.frame_len - 16'd54 : f.frame_len - 16'd14;
        pick = $urandom_range(0, 5);
        if (pick < 3)
            f.tcp_offset_byte = 8'h50;
        else if (pick < 5)
            f.tcp_offset_byte = {4'($urandom_range(5, 15)), 4'h0};
        if ($urandom_range(0, 7) != 0)
            f.l4_src_port = srv_port;
        case ($urandom_range(0, 7))
            0: f.tcp_flag_bits = 8'h02;
            1: f.tcp_flag_bits = 8'h12;
            2: f.tcp_flag_bits = 8'h01;
            3: f.tcp_flag_bits = 8'h11;
            4: f.tcp_flag_bits = 8'h10;
            5: f.tcp_flag_bits = 8'h18;
            6: f.tcp_flag_bits = 8'h00;
            default: ;
        endcase
        return f;
    endfunction

    // Offer one frame, hold it until accepted, then queue its expected reply
    task automatic send_frame(input frame_t f);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, f.dns_rcode, f.ack_number, f.seq_number, f.tcp_flag_bits,
                     f.l4_dst_port, f.l4_src_port, f.tcp_offset_byte, f.ip_length,
                     f.ip_proto, f.eth_kind, f.frame_len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_replies.push_back(classify_frame(f));
    endtask

    // Stop offering and wait until every expected reply is back
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_server_port(input logic [15:0] port);
        drain_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= port;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        srv_port  = port;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_frame(random_frame());
    endtask

    // Each reaction, the length limits and the payload corner cases
    task automatic test_directed();
        frame_t f;
        send_frame(good_frame(0, PROTO_TCP, 8'h12, 16'd100));
        send_frame(good_frame(0, PROTO_TCP, 8'h02, 16'd100));
        send_frame(good_frame(0, PROTO_TCP, 8'h01, 16'd100));
        send_frame(good_frame(0, PROTO_TCP, 8'hFF, 16'd100));
        send_frame(good_frame(0, PROTO_TCP, 8'h13, 16'd60));
        f = good_frame(0, PROTO_TCP, 8'h10, 16'd68);
        f.dns_rcode = 4'd0;
        send_frame(f);
        send_frame(good_frame(0, PROTO_TCP, 8'h10, 16'd67));
        f = good_frame(1, PROTO_TCP, 8'h18, 16'd88);
        f.dns_rcode = 4'hF;
        send_frame(f);
        send_frame(good_frame(1, PROTO_TCP, 8'h10, 16'd87));
        send_frame(good_frame(1, PROTO_TCP, 8'h02, 16'd74));
        send_frame(good_frame(1, PROTO_TCP, 8'h02, 16'd73));
        send_frame(good_frame(0, PROTO_TCP, 8'h02, 16'd53));
        send_frame(good_frame(0, PROTO_UDP, 8'h00, 16'd54));
        send_frame(good_frame(1, PROTO_UDP, 8'h00, 16'd74));
        f = good_frame(0, PROTO_UDP, 8'h00, 16'd90);
        f.l4_src_port = srv_port + 16'd1;
        send_frame(f);
        f = good_frame(0, PROTO_TCP, 8'h02, 16'd90);
        f.eth_kind = 16'h86DE;
        send_frame(f);
        send_frame(good_frame(0, 8'd1, 8'h02, 16'd90));
        // Zero, negative, largest and just-too-large payload lengths
        f = good_frame(0, PROTO_TCP, 8'h02, 16'd54);
        f.ip_length = 16'd40;
        send_frame(f);
        f.ip_length = 16'd10;
        send_frame(f);
        f.ip_length = 16'h7FFF + 16'd40;
        send_frame(f);
        f.ip_length = 16'h8000 + 16'd40;
        send_frame(f);
        f = good_frame(1, PROTO_TCP, 8'h01, 16'd200);
        f.seq_number      = 32'hFFFF_FFFF;
        f.tcp_offset_byte = 8'hFF;
        send_frame(f);
        f = '{default: '0};
        send_frame(f);
        f = '{default: '1};
        send_frame(f);
    endtask

    // Server port at both extremes and a random value, then back to the default
    task automatic test_server_port();
        write_server_port(16'h0000);
        send_random(20);
        write_server_port(16'hFFFF);
        send_random(20);
        write_server_port(16'($urandom));
        send_random(20);
        write_server_port(SERVER_PORT_RST);
        send_random(10);
    endtask

    // Hold the result side long enough to back up the input, then pause the input
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        send_random(40);
        drain_replies();
        send_random(10);
    endtask

    task automatic test_random();
        send_random(400);
        write_server_port(16'($urandom));
        send_random(350);
        idle_on = 1'b0;
        send_random(150);
        drain_replies();
    endtask

    // Result side: random stalls and one long requested hold
    always begin
        @(posedge aclk);
        if (rx_hold_req) begin
            m_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge aclk);
            rx_hold_req = 1'b0;
            m_tready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void compare_field(input string name, input logic [47:0] want_v,
                                          input logic [47:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Check each result word against the oldest expected reply
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: result word with no expected reply, expected none actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_replies.pop_front();
                compare_field("action", 48'(want.action), 48'(m_tuser[2:0]));
                compare_field("reply_seq", 48'(want.reply_seq), 48'(m_tdata[31:0]));
                compare_field("reply_ack", 48'(want.reply_ack), 48'(m_tdata[63:32]));
                compare_field("reply_flags", 48'(want.reply_flags), 48'(m_tdata[71:64]));
                compare_field("reply_src_port", 48'(want.reply_src_port),
                              48'(m_tdata[87:72]));
                compare_field("reply_dst_port", 48'(want.reply_dst_port),
                              48'(m_tdata[103:88]));
                compare_field("bytes_total", want.bytes_total, m_tdata[151:104]);
                compare_field("responses_total", 48'(want.responses_total),
                              48'(m_tdata[183:152]));
                compare_field("rcode_total", 48'(want.rcode_total), 48'(m_tdata[215:184]));
            end
        end
    end

    initial begin
        byte_count = '0;
        rsp_count  = '0;
        srv_port   = SERVER_PORT_RST;
        for (int i = 0; i < 16; i++)
            rcode_count[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_server_port();
        test_backpressure();
        test_random();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
